@@ rtl/core/bth_pkg.sv @@
package bth_pkg;

  localparam int TILE_W = 13;
  localparam int PIX_W  = 8;
  localparam int ANG_W  = 17;
  localparam int H_W    = 25;
  localparam int S_W    = 17;

  localparam logic [TILE_W-1:0] TILE_THIRD_RST = 13'd512;
  localparam logic              MIRROR_RST     = 1'b0;

  localparam int COORD_BITS_DEF     = 14;
  localparam int COS_TABLE_BITS_DEF = 10;

  localparam logic CFG_TILE_THIRD = 1'b0;
  localparam logic CFG_MIRROR     = 1'b1;

  localparam int H_PEAK = 162;
  localparam int H_HALF = 81;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] SERIES_DIV [10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
    64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  typedef enum logic [1:0] {
    BAND_NONE = 2'd0,
    BAND_RISE = 2'd1,
    BAND_FLAT = 2'd2,
    BAND_EASE = 2'd3
  } band_e;

  typedef struct packed {
    band_e            band;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } pix_t;

  // cosine of a Q30 angle, rounded to Q16, clamped to one
  function automatic logic [ANG_W-1:0] cos_series(input logic [63:0] th);
    logic [63:0] th2;
    logic [63:0] sum;
    logic [63:0] term;
    th2  = (th * th) >> 30;
    sum  = ONE_Q30;
    term = ONE_Q30;
    for (int k = 0; k < 10; k++) begin
      term = ((term * th2) >> 30) / SERIES_DIV[k];
      if (k % 2 == 1) begin
        sum = sum + term;
      end else begin
        sum = sum - term;
      end
    end
    sum = (sum + 64'd8192) >> 14;
    if (sum > 64'd65536) begin
      sum = 64'd65536;
    end
    return sum[ANG_W-1:0];
  endfunction

endpackage

@@ rtl/core/banked_track_height_offset_top.sv @@
// Height offset for a straight-into-banking heightmap tile, one RGBA pixel
// per beat. The input channel carries the pixel column, row and its four
// samples; the output channel carries red, green and blue raised by the
// height offset (modulo 256) and alpha unchanged, one beat per input beat,
// in order.
// Configuration: write tile_third (index 0) or mirror_rows (index 1) through
// cfg_we_i / cfg_idx_i / cfg_data_i while no pixel is in flight.
// Throughput: one pixel per cycle while no output beat is stalled. Stages:
// an input stage, the long division of the column angle (one quotient bit
// per stage), the angle fold, the cosine ROM read, the profile stage and
// the offset multiply.
// Reset: tile_third returns to 512, mirror_rows to 0, the pipeline empties.
// Stall: while an output beat is stalled every stage holds, and the input
// channel is stalled in the same cycle; bubbles pass through freely.
module banked_track_height_offset_top #(
  parameter int COORD_BITS     = bth_pkg::COORD_BITS_DEF,
  parameter int COS_TABLE_BITS = bth_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [bth_pkg::TILE_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [COORD_BITS-1:0]        col_i,
  input  logic [COORD_BITS-1:0]        row_i,
  input  logic [bth_pkg::PIX_W-1:0]    red_in_i,
  input  logic [bth_pkg::PIX_W-1:0]    green_in_i,
  input  logic [bth_pkg::PIX_W-1:0]    blue_in_i,
  input  logic [bth_pkg::PIX_W-1:0]    alpha_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bth_pkg::PIX_W-1:0]    red_out_o,
  output logic [bth_pkg::PIX_W-1:0]    green_out_o,
  output logic [bth_pkg::PIX_W-1:0]    blue_out_o,
  output logic [bth_pkg::PIX_W-1:0]    alpha_out_o
);

  localparam int TW        = bth_pkg::TILE_W;
  localparam int T3W       = bth_pkg::TILE_W + 2;
  localparam int AW        = bth_pkg::ANG_W;
  localparam int SW        = ((COORD_BITS > 15) ? COORD_BITS : 15) + 1;
  localparam int CW        = SW + 4;
  localparam int TAB_N     = 1 << COS_TABLE_BITS;
  localparam int IW        = COS_TABLE_BITS + 1;
  localparam int IDX_SHIFT = 15 - COS_TABLE_BITS;
  localparam int IDX_HALF  = 1 << (IDX_SHIFT - 1);
  localparam int HW        = bth_pkg::H_W;
  localparam int PW        = bth_pkg::H_W + bth_pkg::S_W;

  typedef logic [AW-1:0] cos_tab_t [TAB_N+1];

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t t;
    for (int i = 0; i <= TAB_N; i++) begin
      t[i] = bth_pkg::cos_series((bth_pkg::PI_Q30 * 64'(i)) >> (COS_TABLE_BITS + 1));
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  function automatic logic [IW:0] fold_angle(input logic [AW-1:0] a);
    logic [AW:0] p;
    logic [AW:0] q;
    logic [AW:0] r;
    logic        neg;
    p = {1'b0, a};
    if (p > 18'd65536) begin
      p = 18'd131072 - p;
    end
    if (p <= 18'd32768) begin
      q   = p;
      neg = 1'b0;
    end else begin
      q   = 18'd65536 - p;
      neg = 1'b1;
    end
    r = (q + 18'(IDX_HALF)) >> IDX_SHIFT;
    if (r > 18'(TAB_N)) begin
      r = 18'(TAB_N);
    end
    return {neg, r[IW-1:0]};
  endfunction

  logic [TW-1:0] tile_third_q;
  logic          mirror_q;
  logic          en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_third_q <= bth_pkg::TILE_THIRD_RST;
      mirror_q     <= bth_pkg::MIRROR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bth_pkg::CFG_TILE_THIRD: tile_third_q <= cfg_data_i;
        bth_pkg::CFG_MIRROR:     mirror_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // input stage: folded row and its tenfold
  logic [T3W-1:0]       d3;
  logic signed [SW-1:0] cy_d;
  logic signed [CW-1:0] c10_d;

  assign d3    = T3W'(T3W'(tile_third_q) * T3W'(3));
  assign cy_d  = mirror_q ? (signed'(SW'(d3)) - signed'(SW'(row_i))) : signed'(SW'(row_i));
  assign c10_d = CW'(cy_d) * CW'(10);

  logic                  p_vld_q;
  bth_pkg::pix_t         p_pix_q;
  logic [COORD_BITS-1:0] p_col_q;
  logic signed [SW-1:0]  p_cy_q;
  logic signed [CW-1:0]  p_c10_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_pix_q <= '{band: bth_pkg::BAND_NONE, red: red_in_i, green: green_in_i,
                   blue: blue_in_i, alpha: alpha_in_i};
      p_col_q <= col_i;
      p_cy_q  <= cy_d;
      p_c10_q <= c10_d;
    end
  end

  // band select and vertical numerator
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] d5;
  logic signed [CW-1:0] d25;
  logic signed [CW-1:0] d26;
  logic signed [CW-1:0] d30;
  logic signed [CW-1:0] rise_n;
  logic signed [CW-1:0] ease_n;
  bth_pkg::band_e       band;
  bth_pkg::pix_t        p_pix;
  logic [TW-1:0]        vrem;
  logic [AW-1:0]        vlo;

  assign dx     = signed'(CW'(tile_third_q));
  assign d5     = dx * CW'(5);
  assign d25    = dx * CW'(25);
  assign d26    = dx * CW'(26);
  assign d30    = dx * CW'(30);
  assign rise_n = dx * CW'(9) - (CW'(p_cy_q) <<< 1);
  assign ease_n = p_c10_q - d26;

  always_comb begin
    if (tile_third_q == '0) begin
      band = bth_pkg::BAND_NONE;
    end else if (p_c10_q >= d5 && p_c10_q <= d25) begin
      band = bth_pkg::BAND_RISE;
    end else if (p_c10_q > d25 && p_c10_q <= d26) begin
      band = bth_pkg::BAND_FLAT;
    end else if (p_c10_q > d26 && p_c10_q < d30) begin
      band = bth_pkg::BAND_EASE;
    end else begin
      band = bth_pkg::BAND_NONE;
    end
  end

  always_comb begin
    case (band)
      bth_pkg::BAND_RISE: begin
        vrem = {1'b0, rise_n[15:4]};
        vlo  = {rise_n[3:0], 13'd0};
      end
      bth_pkg::BAND_EASE: begin
        vrem = {1'b0, ease_n[14:3]};
        vlo  = {ease_n[2:0], 14'd0};
      end
      default: begin
        vrem = '0;
        vlo  = '0;
      end
    endcase
  end

  always_comb begin
    p_pix      = p_pix_q;
    p_pix.band = band;
  end

  logic          q_vld;
  bth_pkg::pix_t q_pix;
  logic [AW-1:0] hang;
  logic [AW-1:0] vang;

  bth_div_pipe #(
    .COORD_BITS(COORD_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_vld_q),
    .pix_i   (p_pix),
    .col_i   (p_col_q),
    .vrem_i  (vrem),
    .vlo_i   (vlo),
    .div_i   (tile_third_q),
    .div3_i  (d3),
    .valid_o (q_vld),
    .pix_o   (q_pix),
    .hang_o  (hang),
    .vang_o  (vang)
  );

  // fold angles to table index
  logic          a_vld_q;
  bth_pkg::pix_t a_pix_q;
  logic [IW:0]   a_h_q;
  logic [IW:0]   a_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pix_q <= q_pix;
      a_h_q   <= fold_angle(hang);
      a_v_q   <= fold_angle(vang);
    end
  end

  // cosine ROM read
  logic          b_vld_q;
  bth_pkg::pix_t b_pix_q;
  logic [AW-1:0] b_hmag_q;
  logic [AW-1:0] b_vmag_q;
  logic          b_hneg_q;
  logic          b_vneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_pix_q  <= a_pix_q;
      b_hmag_q <= COS_TAB[a_h_q[IW-1:0]];
      b_vmag_q <= COS_TAB[a_v_q[IW-1:0]];
      b_hneg_q <= a_h_q[IW];
      b_vneg_q <= a_v_q[IW];
    end
  end

  // profile and weight
  logic signed [AW:0]   ch;
  logic signed [AW:0]   cv;
  logic [AW:0]          vsum;
  logic signed [AW+1:0] hdiff;
  logic [HW-1:0]        h_d;
  logic [bth_pkg::S_W-1:0] s16_d;

  assign ch    = b_hneg_q ? -signed'({1'b0, b_hmag_q}) : signed'({1'b0, b_hmag_q});
  assign cv    = b_vneg_q ? -signed'({1'b0, b_vmag_q}) : signed'({1'b0, b_vmag_q});
  assign vsum  = unsigned'(18'sd65536 + cv);
  assign hdiff = 19'sd65536 - (AW+2)'(ch);
  assign s16_d = hdiff[AW:1];

  always_comb begin
    case (b_pix_q.band)
      bth_pkg::BAND_RISE: h_d = HW'(32'(vsum) * 32'(bth_pkg::H_PEAK));
      bth_pkg::BAND_EASE: h_d = HW'(32'(vsum) * 32'(bth_pkg::H_HALF));
      bth_pkg::BAND_FLAT: h_d = HW'(32'(bth_pkg::H_PEAK) << 16);
      default:            h_d = '0;
    endcase
  end

  logic                    c_vld_q;
  bth_pkg::pix_t           c_pix_q;
  logic [HW-1:0]           c_h_q;
  logic [bth_pkg::S_W-1:0] c_s16_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_pix_q <= b_pix_q;
      c_h_q   <= h_d;
      c_s16_q <= s16_d;
    end
  end

  // offset multiply and output register
  logic [PW-1:0]             prod;
  logic [bth_pkg::PIX_W-1:0] offset;

  assign prod   = PW'(c_h_q) * PW'(c_s16_q);
  assign offset = prod[39:32];

  logic                      out_vld_q;
  logic [bth_pkg::PIX_W-1:0] red_q;
  logic [bth_pkg::PIX_W-1:0] green_q;
  logic [bth_pkg::PIX_W-1:0] blue_q;
  logic [bth_pkg::PIX_W-1:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= c_pix_q.red + offset;
      green_q <= c_pix_q.green + offset;
      blue_q  <= c_pix_q.blue + offset;
      alpha_q <= c_pix_q.alpha;
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign alpha_out_o = alpha_q;

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output beat stalled");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |-> c_s16_q <= 17'd65536)
    else $error("horizontal weight out of range");

  a_no_band_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q && c_pix_q.band == bth_pkg::BAND_NONE |-> c_h_q == '0)
    else $error("height non-zero outside every band");

endmodule

@@ rtl/core/bth_div_pipe.sv @@
module bth_div_pipe #(
  parameter int COORD_BITS = bth_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  bth_pkg::pix_t                 pix_i,
  input  logic [COORD_BITS-1:0]         col_i,
  input  logic [bth_pkg::TILE_W-1:0]    vrem_i,
  input  logic [bth_pkg::ANG_W-1:0]     vlo_i,
  input  logic [bth_pkg::TILE_W-1:0]    div_i,
  input  logic [bth_pkg::TILE_W+1:0]    div3_i,
  output logic                          valid_o,
  output bth_pkg::pix_t                 pix_o,
  output logic [bth_pkg::ANG_W-1:0]     hang_o,
  output logic [bth_pkg::ANG_W-1:0]     vang_o
);

  localparam int HSTEPS = COORD_BITS + 16;
  localparam int VSTART = HSTEPS - bth_pkg::ANG_W;
  localparam int TW     = bth_pkg::TILE_W;
  localparam int T3W    = bth_pkg::TILE_W + 2;
  localparam int AW     = bth_pkg::ANG_W;

  logic [HSTEPS-1:0]     vld_q;
  bth_pkg::pix_t         pix_q [HSTEPS];
  logic [T3W-1:0]        hr_q  [HSTEPS];
  logic [COORD_BITS-1:0] hn_q  [HSTEPS];
  logic [AW-1:0]         hq_q  [HSTEPS];
  logic [TW-1:0]         vr_q  [HSTEPS];
  logic [AW-1:0]         vn_q  [HSTEPS];
  logic [AW-1:0]         vq_q  [HSTEPS];

  for (genvar i = 0; i < HSTEPS; i++) begin : g_stg
    logic                  vld_in;
    bth_pkg::pix_t         pix_in;
    logic [T3W-1:0]        hr_in;
    logic [COORD_BITS-1:0] hn_in;
    logic [AW-1:0]         hq_in;
    logic [TW-1:0]         vr_in;
    logic [AW-1:0]         vn_in;
    logic [AW-1:0]         vq_in;
    logic [T3W:0]          hrs;
    logic                  hge;
    logic [T3W-1:0]        hr_d;
    logic [TW-1:0]         vr_d;
    logic [AW-1:0]         vn_d;
    logic [AW-1:0]         vq_d;

    if (i == 0) begin : g_first
      assign vld_in = valid_i;
      assign pix_in = pix_i;
      assign hr_in  = '0;
      assign hn_in  = col_i;
      assign hq_in  = '0;
      assign vr_in  = vrem_i;
      assign vn_in  = vlo_i;
      assign vq_in  = '0;
    end else begin : g_next
      assign vld_in = vld_q[i-1];
      assign pix_in = pix_q[i-1];
      assign hr_in  = hr_q[i-1];
      assign hn_in  = hn_q[i-1];
      assign hq_in  = hq_q[i-1];
      assign vr_in  = vr_q[i-1];
      assign vn_in  = vn_q[i-1];
      assign vq_in  = vq_q[i-1];
    end

    assign hrs  = {hr_in, hn_in[COORD_BITS-1]};
    assign hge  = hrs >= {1'b0, div3_i};
    assign hr_d = hge ? T3W'(hrs - {1'b0, div3_i}) : hrs[T3W-1:0];

    if (i >= VSTART) begin : g_vstep
      logic [TW:0] vrs;
      logic        vge;
      assign vrs  = {vr_in, vn_in[AW-1]};
      assign vge  = vrs >= {1'b0, div_i};
      assign vr_d = vge ? TW'(vrs - {1'b0, div_i}) : vrs[TW-1:0];
      assign vn_d = {vn_in[AW-2:0], 1'b0};
      assign vq_d = {vq_in[AW-2:0], vge};
    end else begin : g_vhold
      assign vr_d = vr_in;
      assign vn_d = vn_in;
      assign vq_d = vq_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pix_q[i] <= pix_in;
        hr_q[i]  <= hr_d;
        hn_q[i]  <= {hn_in[COORD_BITS-2:0], 1'b0};
        hq_q[i]  <= {hq_in[AW-2:0], hge};
        vr_q[i]  <= vr_d;
        vn_q[i]  <= vn_d;
        vq_q[i]  <= vq_d;
      end
    end
  end

  assign valid_o = vld_q[HSTEPS-1];
  assign pix_o   = pix_q[HSTEPS-1];
  assign hang_o  = hq_q[HSTEPS-1];
  assign vang_o  = vq_q[HSTEPS-1];

endmodule
